@@ rtl/ets_pkg.sv @@
// Shared types, codes and character classes of the expression token scanner.
`timescale 1ns / 1ps

package ets_pkg;

   localparam int KIND_W  = 3;
   localparam int FIELD_W = 16;
   localparam int CHAR_W  = 8;
   localparam int ERR_W   = 2;
   localparam int MODE_W  = 3;

   localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OPER   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LPAREN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 3'd4;
   localparam logic [KIND_W-1:0] KIND_COMMA  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd6;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd7;

   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LONE_DOT = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNDEF    = 2'd2;
   localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd3;

   localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INT   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DOT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FRAC  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_IDENT = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ERROR = 3'd5;

   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_UNDER  = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_CARET  = 8'h5E;

   // Result queue: eight entries, so that two results per request always fit.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;
   localparam int PUSH_W      = 2;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [FIELD_W-1:0] token_start;
      logic [FIELD_W-1:0] token_length;
      logic [CHAR_W-1:0]  single_char;
      logic [ERR_W-1:0]   error_code;
      logic               last_of_run;
   } result_type;

   typedef struct packed {
      logic [PUSH_W-1:0] count;
      result_type        first;
      result_type        second;
   } push_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [CHAR_W-1:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_oper(input logic [CHAR_W-1:0] b);
      return (b == CHAR_PLUS) || (b == CHAR_MINUS) || (b == CHAR_STAR) ||
             (b == CHAR_SLASH) || (b == CHAR_CARET);
   endfunction

endpackage

@@ rtl/ets_if.sv @@
// Request and result channel interfaces of the expression token scanner.
`timescale 1ns / 1ps

interface ets_req_if import ets_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface ets_rsp_if import ets_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  token_kind;
   logic [FIELD_W-1:0] token_start;
   logic [FIELD_W-1:0] token_length;
   logic [CHAR_W-1:0]  single_char;
   logic [ERR_W-1:0]   error_code;
   logic               last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output single_char, output error_code,
                   output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_length, input single_char, input error_code,
                 input last_of_run, output ready);
endinterface

@@ rtl/expression_token_scanner.sv @@
// Top level of the expression token scanner.
// The scanner splits arithmetic expression text into tokens. Requests on
// req_chan carry one text byte each; a zero byte ends the text. Each request
// yields none, one or two results on rsp_chan, each giving kind, start offset,
// length, the character of operator and punctuation tokens and an error code;
// last_of_run marks the final result of a request.
// A request accepted at one clock edge is decoded from the input register in
// the following cycle; its results are queued and offered on rsp_chan in order.
// One request can be taken every cycle while the queue has room; the mode,
// position and pending token start are registers updated once per request.
// Results wait in an eight-entry queue. While the receiver stalls, requests
// are still taken until more than four results are queued, after which
// req_chan.ready is held low until the queue is back to four results or fewer.
// Reset is synchronous and active high; it empties the queue and returns the
// scanner to idle at offset zero, ready on the next cycle.
`timescale 1ns / 1ps

module expression_token_scanner import ets_pkg::*; #(
   parameter int MAX_TEXT_LENGTH = 65536
) (
   input logic        clock,
   input logic        reset,
   ets_req_if.sink    req_chan,
   ets_rsp_if.source  rsp_chan
);

   push_type   push;
   logic       room;
   result_type out_data;

   assign req_chan.ready = room;

   ets_scan_core #(
      .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_chan.valid && req_chan.ready),
      .req_text_byte (req_chan.text_byte),
      .push          (push)
   );

   ets_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.token_kind   = out_data.token_kind;
   assign rsp_chan.token_start  = out_data.token_start;
   assign rsp_chan.token_length = out_data.token_length;
   assign rsp_chan.single_char  = out_data.single_char;
   assign rsp_chan.error_code   = out_data.error_code;
   assign rsp_chan.last_of_run  = out_data.last_of_run;

endmodule

@@ rtl/ets_scan_core.sv @@
// Input register, scan state and one-pass token decode of the scanner.
`timescale 1ns / 1ps

module ets_scan_core import ets_pkg::*; #(
   parameter int MAX_TEXT_LENGTH = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic [CHAR_W-1:0] req_text_byte,
   output push_type          push
);

   localparam int POS_W = $clog2(MAX_TEXT_LENGTH + 1);
   localparam int LEN_W = (POS_W > FIELD_W) ? POS_W : FIELD_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_TEXT_LENGTH);
   localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'({FIELD_W{1'b1}});

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_byte_ff;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  pstart_ff, pstart_in;

   logic              has_pending;
   logic              emit_a, emit_b;
   logic              absorbed;
   logic [LEN_W-1:0]  pos_ext, pstart_ext, span;
   result_type        res_a, res_b;
   logic [CHAR_W-1:0] b;

   assign in_valid_in = req_accept;
   assign b           = in_byte_ff;
   assign pos_ext     = LEN_W'(pos_ff);
   assign pstart_ext  = LEN_W'(pstart_ff);
   assign span        = pos_ext - pstart_ext;
   assign has_pending = (mode_ff == MODE_INT) || (mode_ff == MODE_FRAC) ||
                        (mode_ff == MODE_IDENT);

   // A byte that continues the pending number or identifier.
   always_comb begin
      unique case (mode_ff)
         MODE_INT:   absorbed = is_digit(b) || (b == CHAR_DOT);
         MODE_FRAC:  absorbed = is_digit(b);
         MODE_DOT:   absorbed = is_digit(b);
         MODE_IDENT: absorbed = is_alpha(b) || is_digit(b) || (b == CHAR_UNDER);
         default:    absorbed = 1'b0;
      endcase
   end

   always_comb begin
      res_a              = '0;
      res_a.token_kind   = (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
      res_a.token_start  = pstart_ext[FIELD_W-1:0];
      res_a.token_length = (span > LEN_SAT) ? {FIELD_W{1'b1}} : span[FIELD_W-1:0];
      res_b              = '0;
      emit_a             = 1'b0;
      emit_b             = 1'b0;
      mode_in            = mode_ff;
      pos_in             = pos_ff;
      pstart_in          = pstart_ff;
      if (in_valid_ff) begin
         priority if (mode_ff == MODE_ERROR) begin
            if (b == CHAR_NUL) begin
               mode_in   = MODE_IDLE;
               pos_in    = '0;
               pstart_in = '0;
            end
         end else if (b == CHAR_NUL) begin
            emit_b = 1'b1;
            if (mode_ff == MODE_DOT) begin
               res_b.token_kind  = KIND_ERROR;
               res_b.token_start = pstart_ext[FIELD_W-1:0];
               res_b.error_code  = ERR_LONE_DOT;
            end else begin
               emit_a            = has_pending;
               res_b.token_kind  = KIND_END;
               res_b.token_start = pos_ext[FIELD_W-1:0];
            end
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            pstart_in = '0;
         end else if (pos_ff >= POS_LIMIT) begin
            emit_b            = 1'b1;
            res_b.token_kind  = KIND_ERROR;
            res_b.token_start = pos_ext[FIELD_W-1:0];
            res_b.error_code  = ERR_TOO_LONG;
            mode_in           = MODE_ERROR;
         end else if (absorbed) begin
            pos_in = pos_ff + POS_W'(1);
            if (mode_ff == MODE_DOT || (mode_ff == MODE_INT && b == CHAR_DOT)) begin
               mode_in = MODE_FRAC;
            end
         end else if (mode_ff == MODE_DOT) begin
            emit_b            = 1'b1;
            res_b.token_kind  = KIND_ERROR;
            res_b.token_start = pstart_ext[FIELD_W-1:0];
            res_b.error_code  = ERR_LONE_DOT;
            mode_in           = MODE_ERROR;
         end else begin
            emit_a  = has_pending;
            mode_in = MODE_IDLE;
            pos_in  = pos_ff + POS_W'(1);
            res_b.token_start = pos_ext[FIELD_W-1:0];
            priority if (b == CHAR_SPACE || b == CHAR_TAB) begin
               mode_in = MODE_IDLE;
            end else if (is_digit(b)) begin
               mode_in   = MODE_INT;
               pstart_in = pos_ff;
            end else if (b == CHAR_DOT) begin
               mode_in   = MODE_DOT;
               pstart_in = pos_ff;
            end else if (is_alpha(b) || b == CHAR_UNDER) begin
               mode_in   = MODE_IDENT;
               pstart_in = pos_ff;
            end else if (is_oper(b) || b == CHAR_LPAREN || b == CHAR_RPAREN ||
                         b == CHAR_COMMA) begin
               emit_b             = 1'b1;
               res_b.token_length = FIELD_W'(1);
               res_b.single_char  = b;
               priority if (is_oper(b)) begin
                  res_b.token_kind = KIND_OPER;
               end else if (b == CHAR_LPAREN) begin
                  res_b.token_kind = KIND_LPAREN;
               end else if (b == CHAR_RPAREN) begin
                  res_b.token_kind = KIND_RPAREN;
               end else begin
                  res_b.token_kind = KIND_COMMA;
               end
            end else begin
               emit_b            = 1'b1;
               res_b.token_kind  = KIND_ERROR;
               res_b.error_code  = ERR_UNDEF;
               mode_in           = MODE_ERROR;
            end
         end
      end
   end

   // The pending token, when there is one, always leaves ahead of the other result.
   always_comb begin
      push.count              = PUSH_W'(emit_a) + PUSH_W'(emit_b);
      push.first              = emit_a ? res_a : res_b;
      push.first.last_of_run  = !(emit_a && emit_b);
      push.second             = res_b;
      push.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         pstart_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         pstart_ff   <= pstart_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_text_byte;
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("Position has run past the text limit.");

   a_start_behind_pos: assert property (@(posedge clock) disable iff (reset)
      pstart_ff <= pos_ff)
      else $error("Pending start lies beyond the current position.");

   a_terminator_resets: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_byte_ff == CHAR_NUL |=> mode_ff == MODE_IDLE && pos_ff == '0)
      else $error("A terminator did not return the scanner to idle.");

endmodule

@@ rtl/ets_result_queue.sv @@
// Result queue that takes up to two results a cycle and hands out one while out_ready is high.
`timescale 1ns / 1ps

module ets_result_queue import ets_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // Room for the request in the input register and for one more behind it.
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 4));

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != '0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == PUSH_W'(2)) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("Result queue has overflowed.");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      count_ff == QCNT_W'(QUEUE_DEPTH) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("Full queue pointers disagree.");

   a_run_closed: assert property (@(posedge clock) disable iff (reset)
      push.count == PUSH_W'(2) |-> !push.first.last_of_run && push.second.last_of_run)
      else $error("A pair of results is not marked as one run.");

endmodule
